FILE: hdl/debounced_pulse_tachometer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced pulse tachometer
// Shared forms of the concurrent checks used by the core's modules.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PULSE_TACHOMETER_CORE_ASSERT_SVH
`define DEBOUNCED_PULSE_TACHOMETER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tachometer check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tachometer sequence check failed");

`endif

FILE: hdl/dpt_pkg.sv
// ----------------------------------------------------------------------------
// Debounced pulse tachometer package
// Widths, reset values, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int TIME_W     = 48;
  localparam int TALLY_W    = 32;
  localparam int DEB_W      = 20;
  localparam int SCALE_W    = 12;
  localparam int RPM_W      = 32;
  localparam int PROD_W     = TALLY_W + SCALE_W;
  localparam int HZ_W       = 20;
  localparam int NUM_W      = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_STEPS  = RPM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [HZ_W-1:0]    TIMER_HZ      = HZ_W'(1000000);
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = DEB_W'(10000);
  localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(60);

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 1'b1;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_SCALE,
    ST_MUL_HZ,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept_edge;
    logic accept_query;
    logic mul_scale;
    logic mul_hz;
    logic div_init;
    logic div_step;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_skip;
    logic div_last;
  } dp_status_t;

endpackage

FILE: hdl/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences the accept, multiply, divide and result steps of one item.
// ----------------------------------------------------------------------------
module dpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                opcode,
  output logic                in_stall,
  input  dpt_pkg::dp_status_t status,
  output dpt_pkg::ctrl_cmd_t  cmd
);
  import dpt_pkg::*;

  `include "debounced_pulse_tachometer_core_assert.svh"

  state_t state;
  state_t state_next;
  logic   take;

  assign take = in_valid && (state == ST_IDLE) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (opcode == OP_QUERY)) begin
          state_next = ST_MUL_SCALE;
        end
      end
      ST_MUL_SCALE: state_next = ST_MUL_HZ;
      ST_MUL_HZ:    state_next = ST_DIV_INIT;
      ST_DIV_INIT:  state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_skip || status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = !((state == ST_IDLE) && status.out_free);
    case (state)
      ST_IDLE: begin
        cmd.accept_edge  = take && (opcode == OP_EDGE);
        cmd.accept_query = take && (opcode == OP_QUERY);
      end
      ST_MUL_SCALE: cmd.mul_scale = 1'b1;
      ST_MUL_HZ:    cmd.mul_hz = 1'b1;
      ST_DIV_INIT:  cmd.div_init = 1'b1;
      ST_DIV:       cmd.div_step = !status.div_skip;
      ST_FINISH:    cmd.load_result = status.out_free;
      default:      cmd = '0;
    endcase
  end

  `DPT_ASSERT_NEXT(a_init_then_div, clk, rst, state == ST_DIV_INIT, state == ST_DIV)
  `DPT_ASSERT_SAME(a_result_slot_free, clk, rst, cmd.load_result, status.out_free)
  `DPT_ASSERT_SAME(a_one_command, clk, rst, 1'b1, $onehot0(cmd))

endmodule

FILE: hdl/dpt_datapath.sv
// ----------------------------------------------------------------------------
// Tachometer datapath
// Configuration, pulse and query state, multiplier, bit-serial divider and
// the output register.
// ----------------------------------------------------------------------------
module dpt_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dpt_pkg::TIME_W-1:0]     timestamp_us,
  input  dpt_pkg::ctrl_cmd_t             cmd,
  output dpt_pkg::dp_status_t            status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           edge_accepted,
  output logic [dpt_pkg::RPM_W-1:0]      rpm,
  output logic [dpt_pkg::TALLY_W-1:0]    pulse_total
);
  import dpt_pkg::*;

  `include "debounced_pulse_tachometer_core_assert.svh"

  logic [DEB_W-1:0]   debounce_us;
  logic [SCALE_W-1:0] per_minute_scale;
  logic [TALLY_W-1:0] pulse_tally;
  logic [TIME_W-1:0]  last_edge_time;
  logic [TALLY_W-1:0] tally_at_query;
  logic [TIME_W-1:0]  time_at_query;
  logic [TALLY_W-1:0] dp;
  logic [TIME_W-1:0]  dt;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   num;
  logic [TIME_W-1:0]  rem;
  logic [RPM_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic               sat;
  logic               zero;

  logic [TIME_W-1:0]  since;
  logic               pass;
  logic [TIME_W:0]    shifted;
  logic [TIME_W:0]    diff;
  logic               ge;

  assign since   = timestamp_us - last_edge_time;
  assign pass    = since > TIME_W'(debounce_us);
  assign shifted = {rem, quo[RPM_W-1]};
  assign diff    = shifted - {1'b0, dt};
  assign ge      = shifted >= {1'b0, dt};

  assign status.out_free = !out_valid || !out_stall;
  assign status.div_skip = sat || zero;
  assign status.div_last = cnt == CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us      <= DEBOUNCE_RST;
      per_minute_scale <= SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_us <= cfg_data[DEB_W-1:0];
        CFG_SCALE:    per_minute_scale <= cfg_data[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_tally    <= '0;
      last_edge_time <= '0;
      tally_at_query <= '0;
      time_at_query  <= '0;
    end else if (cmd.accept_edge && pass) begin
      pulse_tally    <= pulse_tally + TALLY_W'(1);
      last_edge_time <= timestamp_us;
    end else if (cmd.accept_query) begin
      tally_at_query <= pulse_tally;
      time_at_query  <= timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      dp <= pulse_tally - tally_at_query;
      dt <= timestamp_us - time_at_query;
    end
    if (cmd.mul_scale) begin
      prod <= PROD_W'(dp) * PROD_W'(per_minute_scale);
    end
    if (cmd.mul_hz) begin
      num <= NUM_W'(prod) * NUM_W'(TIMER_HZ);
    end
    if (cmd.div_init) begin
      zero <= dt == '0;
      sat  <= TIME_W'(num[NUM_W-1:RPM_W]) >= dt;
      rem  <= TIME_W'(num[NUM_W-1:RPM_W]);
      quo  <= num[RPM_W-1:0];
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo <= {quo[RPM_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept_edge || cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_edge) begin
      edge_accepted <= pass;
      rpm           <= '0;
      pulse_total   <= pass ? pulse_tally + TALLY_W'(1) : pulse_tally;
    end else if (cmd.load_result) begin
      edge_accepted <= 1'b0;
      rpm           <= zero ? '0 : (sat ? '1 : quo);
      pulse_total   <= pulse_tally;
    end
  end

  `DPT_ASSERT_SAME(a_rem_below_divisor, clk, rst, cmd.div_step, rem < dt)
  `DPT_ASSERT_SAME(a_edge_has_no_rate, clk, rst, out_valid && edge_accepted, rpm == '0)

endmodule

FILE: hdl/debounced_pulse_tachometer_core.sv
// An edge beat gives its result in the cycle after acceptance. A query beat
// runs two multiply steps, one divide setup and 32 restoring divide steps
// (skipped when the interval is zero or the rate saturates), then loads its
// result once the output slot is free. One item is handled at a time: a new
// item is taken only when idle with the output slot free.
// Reset clears all pulse and query state and restores the register defaults.
// ----------------------------------------------------------------------------
// Debounced pulse tachometer core
// Counts debounced sensor edges and reports the pulse rate between queries.
// ----------------------------------------------------------------------------
module debounced_pulse_tachometer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [dpt_pkg::TIME_W-1:0]     timestamp_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           edge_accepted,
  output logic [dpt_pkg::RPM_W-1:0]      rpm,
  output logic [dpt_pkg::TALLY_W-1:0]    pulse_total
);
  import dpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dpt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .timestamp_us  (timestamp_us),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .edge_accepted (edge_accepted),
    .rpm           (rpm),
    .pulse_total   (pulse_total)
  );

endmodule
